### rtl/core/btmc_pkg.sv
// Shared types and constants for the battery thermal mode controller.
// Depends on nothing; every other file in rtl/core imports it.
package btmc_pkg;

  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_PRECOND  = 3'd1,
    MODE_COOLING  = 3'd2,
    MODE_DERATE   = 3'd3,
    MODE_SHUTDOWN = 3'd4,
    MODE_TIMEOUT  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_TIMEOUT  = 2'd1,
    FAULT_CRITICAL = 2'd2,
    FAULT_DERATE   = 2'd3
  } fault_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRECOND_ON  = 3'd0,
    REG_PRECOND_OFF = 3'd1,
    REG_COOL_ON     = 3'd2,
    REG_COOL_OFF    = 3'd3,
    REG_DERATE_ON   = 3'd4,
    REG_DERATE_OFF  = 3'd5,
    REG_SHUTDOWN    = 3'd6,
    REG_DERATE_PCT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] precond_on;
    logic signed [TEMP_W-1:0] precond_off;
    logic signed [TEMP_W-1:0] cool_on;
    logic signed [TEMP_W-1:0] cool_off;
    logic signed [TEMP_W-1:0] derate_on;
    logic signed [TEMP_W-1:0] derate_off;
    logic signed [TEMP_W-1:0] shutdown;
    logic [PCT_W-1:0]         derate_pct;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic             pump;
    logic             fan;
    logic             heater;
    logic             lamp;
    logic             chg_en;
    logic [PCT_W-1:0] torque;
    logic [PCT_W-1:0] chg_lim;
    fault_t           fault;
  } result_t;

endpackage

### rtl/core/btmc_cfg_regs.sv
// Threshold and derate-limit register file for the thermal mode controller.
// Depends on btmc_pkg for cfg_t and the register index codes.
module btmc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [btmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btmc_pkg::TEMP_W-1:0]      cfg_data,
  output btmc_pkg::cfg_t                   cfg
);
  import btmc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.precond_on  <= 16'sd50;
      cfg.precond_off <= 16'sd150;
      cfg.cool_on     <= 16'sd400;
      cfg.cool_off    <= 16'sd350;
      cfg.derate_on   <= 16'sd500;
      cfg.derate_off  <= 16'sd450;
      cfg.shutdown    <= 16'sd600;
      cfg.derate_pct  <= 7'd50;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PRECOND_ON:  cfg.precond_on  <= cfg_data;
        REG_PRECOND_OFF: cfg.precond_off <= cfg_data;
        REG_COOL_ON:     cfg.cool_on     <= cfg_data;
        REG_COOL_OFF:    cfg.cool_off    <= cfg_data;
        REG_DERATE_ON:   cfg.derate_on   <= cfg_data;
        REG_DERATE_OFF:  cfg.derate_off  <= cfg_data;
        REG_SHUTDOWN:    cfg.shutdown    <= cfg_data;
        REG_DERATE_PCT:  cfg.derate_pct  <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/btmc_mode_logic.sv
// Combinational mode decision: threshold compares, priority pick, actuator decode.
// Depends on btmc_pkg for cfg_t, mode_t and result_t.
module btmc_mode_logic (
  input  btmc_pkg::cfg_t                    cfg,
  input  btmc_pkg::mode_t                   cur_mode,
  input  logic                              fresh,
  input  logic signed [btmc_pkg::TEMP_W-1:0] temp,
  input  logic                              charging,
  output btmc_pkg::result_t                 res
);
  import btmc_pkg::*;

  logic             pre;
  logic             der;
  logic             cool;
  logic             shut;
  logic [PCT_W-1:0] derated;

  // saturate the derate limit to full scale
  assign derated = (cfg.derate_pct > FULL_PERCENT) ? FULL_PERCENT : cfg.derate_pct;

  assign shut = temp >= cfg.shutdown;
  assign pre  = charging && ((temp <= cfg.precond_on) ||
                ((cur_mode == MODE_PRECOND) && (temp < cfg.precond_off)));
  assign der  = (temp >= cfg.derate_on) ||
                ((cur_mode == MODE_DERATE) && (temp >= cfg.derate_off));
  assign cool = (temp >= cfg.cool_on) ||
                (((cur_mode == MODE_COOLING) || (cur_mode == MODE_DERATE)) &&
                 (temp >= cfg.cool_off));

  always_comb begin
    res = '{mode: MODE_NORMAL, pump: 1'b0, fan: 1'b0, heater: 1'b0, lamp: 1'b0,
            chg_en: 1'b0, torque: FULL_PERCENT, chg_lim: FULL_PERCENT,
            fault: FAULT_NONE};
    if (!fresh) begin
      res.mode    = MODE_TIMEOUT;
      res.pump    = 1'b1;
      res.fan     = 1'b1;
      res.lamp    = 1'b1;
      res.torque  = '0;
      res.chg_lim = '0;
      res.fault   = FAULT_TIMEOUT;
    end else if (shut) begin
      res.mode    = MODE_SHUTDOWN;
      res.pump    = 1'b1;
      res.fan     = 1'b1;
      res.lamp    = 1'b1;
      res.torque  = '0;
      res.chg_lim = '0;
      res.fault   = FAULT_CRITICAL;
    end else if (pre) begin
      res.mode    = MODE_PRECOND;
      res.pump    = 1'b1;
      res.heater  = 1'b1;
      res.chg_lim = '0;
    end else if (der) begin
      res.mode    = MODE_DERATE;
      res.pump    = 1'b1;
      res.fan     = 1'b1;
      res.torque  = derated;
      res.chg_lim = derated;
      res.fault   = FAULT_DERATE;
    end else if (cool) begin
      res.mode    = MODE_COOLING;
      res.pump    = 1'b1;
      res.fan     = 1'b1;
    end else begin
      res.chg_en  = charging;
    end
  end

endmodule

### rtl/core/battery_thermal_mode_controller.sv
// Top level of the battery thermal mode controller: input register, mode state,
// result register. Depends on btmc_pkg, btmc_cfg_regs and btmc_mode_logic.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | status_fresh, pack_temperature, charge_mode
//   out     | out_valid / out_ready| mode_code, pump_on, fan_on, heater_on,
//           |                      | fault_lamp_on, charge_enable, torque_limit,
//           |                      | charge_limit, fault_code
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; a beat lands in the
// input register at the edge that accepts it, then moves on to the result register.
// The mode state advances as a beat moves from the input register to the result
// register, so the next beat always sees the mode left by the one before it.
// A stalled output holds both registers full; in_ready drops only then.
// Synchronous reset empties both stages, restores the threshold defaults and
// returns the mode to normal.
module battery_thermal_mode_controller (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               status_fresh,
  input  logic signed [btmc_pkg::TEMP_W-1:0] pack_temperature,
  input  logic                               charge_mode,
  // output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         mode_code,
  output logic                               pump_on,
  output logic                               fan_on,
  output logic                               heater_on,
  output logic                               fault_lamp_on,
  output logic                               charge_enable,
  output logic [btmc_pkg::PCT_W-1:0]         torque_limit,
  output logic [btmc_pkg::PCT_W-1:0]         charge_limit,
  output logic [1:0]                         fault_code,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [btmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btmc_pkg::TEMP_W-1:0]        cfg_data
);
  import btmc_pkg::*;

  cfg_t                     cfg;
  mode_t                    cur_mode;
  result_t                  res_next;
  result_t                  res;

  // input register
  logic                     s1_valid;
  logic                     s1_fresh;
  logic signed [TEMP_W-1:0] s1_temp;
  logic                     s1_charge;

  logic                     out_load;
  logic                     s1_move;

  // the result register takes a beat when empty or being drained
  assign out_load = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  btmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btmc_mode_logic u_logic (
    .cfg      (cfg),
    .cur_mode (cur_mode),
    .fresh    (s1_fresh),
    .temp     (s1_temp),
    .charging (s1_charge),
    .res      (res_next)
  );

  // control: stage valids and mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      cur_mode  <= MODE_NORMAL;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
      // advance the mode only when a beat actually leaves the input register
      if (s1_move) begin
        cur_mode <= res_next.mode;
      end
    end
  end

  // payload: capture input beat, then result
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_fresh  <= status_fresh;
      s1_temp   <= pack_temperature;
      s1_charge <= charge_mode;
    end
    if (s1_move) begin
      res <= res_next;
    end
  end

  assign mode_code     = res.mode;
  assign pump_on       = res.pump;
  assign fan_on        = res.fan;
  assign heater_on     = res.heater;
  assign fault_lamp_on = res.lamp;
  assign charge_enable = res.chg_en;
  assign torque_limit  = res.torque;
  assign charge_limit  = res.chg_lim;
  assign fault_code    = res.fault;

endmodule

### rtl/core/btmc_checker.sv
// Port-level checker for the battery thermal mode controller, bound to the top.
// Depends on btmc_pkg for mode and fault codes.
module btmc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [2:0]                         mode_code,
  input logic                               fan_on,
  input logic                               heater_on,
  input logic                               fault_lamp_on,
  input logic                               charge_enable,
  input logic [btmc_pkg::PCT_W-1:0]         torque_limit,
  input logic [btmc_pkg::PCT_W-1:0]         charge_limit,
  input logic [1:0]                         fault_code
);
  import btmc_pkg::*;

  // a stalled result beat holds its mode
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode_code))
    else $error("output beat changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // timeout beats carry the timeout fault and zero limits
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode_code == MODE_TIMEOUT) |->
      (fault_code == FAULT_TIMEOUT) && (torque_limit == 0) && (charge_limit == 0)
      && fault_lamp_on)
    else $error("timeout beat with wrong decode");

  // heater runs only in preconditioning, with charging blocked
  a_heater: assert property (@(posedge clk) disable iff (rst)
    out_valid && heater_on |-> (mode_code == MODE_PRECOND) && (charge_limit == 0)
      && !fan_on)
    else $error("heater on outside preconditioning");

  // charge enable only from normal mode, at full torque limit and with no fault
  a_chg_en: assert property (@(posedge clk) disable iff (rst)
    out_valid && charge_enable |-> (mode_code == MODE_NORMAL) &&
      (torque_limit == FULL_PERCENT) && (fault_code == FAULT_NONE))
    else $error("charge enable outside normal mode");

endmodule

bind battery_thermal_mode_controller btmc_checker u_btmc_checker (.*);

### bench/btmc_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the battery thermal mode controller bench: predicts the outcome
// of every accepted tick and checks results in order. Depends on btmc_pkg.
package btmc_tb_pkg;
  import btmc_pkg::*;

  class thermal_scoreboard;
    cfg_t        thresholds;
    mode_t       last_mode;
    result_t     outcome_q[$];
    int unsigned checked;
    int unsigned mismatches;
    int unsigned mode_count[6];

    function new();
      thresholds = '{precond_on: 16'sd50, precond_off: 16'sd150, cool_on: 16'sd400,
                     cool_off: 16'sd350, derate_on: 16'sd500, derate_off: 16'sd450,
                     shutdown: 16'sd600, derate_pct: 7'd50};
      last_mode  = MODE_NORMAL;
      checked    = 0;
      mismatches = 0;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [TEMP_W-1:0] data);
      case (idx)
        REG_PRECOND_ON:  thresholds.precond_on  = data;
        REG_PRECOND_OFF: thresholds.precond_off = data;
        REG_COOL_ON:     thresholds.cool_on     = data;
        REG_COOL_OFF:    thresholds.cool_off    = data;
        REG_DERATE_ON:   thresholds.derate_on   = data;
        REG_DERATE_OFF:  thresholds.derate_off  = data;
        REG_SHUTDOWN:    thresholds.shutdown    = data;
        REG_DERATE_PCT:  thresholds.derate_pct  = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // Work out the outcome of one accepted tick and queue it.
    function void log_tick(logic fresh, logic signed [TEMP_W-1:0] temp, logic charging);
      result_t          r;
      logic [PCT_W-1:0] pct;
      logic             pre;
      logic             der;
      logic             cool;
      pct       = (thresholds.derate_pct > FULL_PERCENT) ? FULL_PERCENT
                                                         : thresholds.derate_pct;
      r         = '0;
      r.mode    = MODE_NORMAL;
      r.fault   = FAULT_NONE;
      r.torque  = FULL_PERCENT;
      r.chg_lim = FULL_PERCENT;
      if (!fresh) begin
        r.mode    = MODE_TIMEOUT;
        r.pump    = 1'b1;
        r.fan     = 1'b1;
        r.lamp    = 1'b1;
        r.torque  = '0;
        r.chg_lim = '0;
        r.fault   = FAULT_TIMEOUT;
      end else begin
        pre  = charging && (temp <= $signed(thresholds.precond_on) ||
               (last_mode == MODE_PRECOND && temp < $signed(thresholds.precond_off)));
        der  = temp >= $signed(thresholds.derate_on) ||
               (last_mode == MODE_DERATE && temp >= $signed(thresholds.derate_off));
        cool = temp >= $signed(thresholds.cool_on) ||
               ((last_mode == MODE_COOLING || last_mode == MODE_DERATE) &&
                temp >= $signed(thresholds.cool_off));
        if (temp >= $signed(thresholds.shutdown)) begin
          r.mode    = MODE_SHUTDOWN;
          r.pump    = 1'b1;
          r.fan     = 1'b1;
          r.lamp    = 1'b1;
          r.torque  = '0;
          r.chg_lim = '0;
          r.fault   = FAULT_CRITICAL;
        end else if (pre) begin
          r.mode    = MODE_PRECOND;
          r.pump    = 1'b1;
          r.heater  = 1'b1;
          r.chg_lim = '0;
        end else if (der) begin
          r.mode    = MODE_DERATE;
          r.pump    = 1'b1;
          r.fan     = 1'b1;
          r.torque  = pct;
          r.chg_lim = pct;
          r.fault   = FAULT_DERATE;
        end else if (cool) begin
          r.mode = MODE_COOLING;
          r.pump = 1'b1;
          r.fan  = 1'b1;
        end else begin
          r.chg_en = charging;
        end
      end
      last_mode = r.mode;
      mode_count[r.mode]++;
      outcome_q.push_back(r);
    endfunction

    function string describe(result_t r);
      return $sformatf({"mode %0d pump %0b fan %0b heater %0b lamp %0b chg_en %0b ",
                        "torque %0d chg_lim %0d fault %0d"},
                       r.mode, r.pump, r.fan, r.heater, r.lamp, r.chg_en,
                       r.torque, r.chg_lim, r.fault);
    endfunction

    function void check_outcome(result_t got);
      result_t want;
      checked++;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result with nothing outstanding: %s", describe(got));
        return;
      end
      want = outcome_q.pop_front();
      if (got.mode !== want.mode || got.pump !== want.pump || got.fan !== want.fan ||
          got.heater !== want.heater || got.lamp !== want.lamp ||
          got.chg_en !== want.chg_en || got.torque !== want.torque ||
          got.chg_lim !== want.chg_lim || got.fault !== want.fault) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: mismatch on result %0d", checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction
  endclass

endpackage

### bench/tb.sv
`timescale 1ns / 100ps
// Top of the bench for battery_thermal_mode_controller: clock, reset, beat drivers,
// monitor and run control. Depends on btmc_pkg and btmc_tb_pkg.
module tb;
  import btmc_pkg::*;
  import btmc_tb_pkg::*;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned TICKS_PER_PHASE = 100;

  // How a phase picks its thresholds.
  typedef enum int {CFG_DEFAULT, CFG_ORDERED, CFG_EXTREME, CFG_SCRAMBLED} cfg_style_t;

  logic                     clk              = 1'b0;
  logic                     rst              = 1'b1;
  logic                     in_valid         = 1'b0;
  logic                     status_fresh     = 1'b0;
  logic signed [TEMP_W-1:0] pack_temperature = '0;
  logic                     charge_mode      = 1'b0;
  logic                     out_ready        = 1'b0;
  logic                     cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index        = '0;
  logic [TEMP_W-1:0]        cfg_data         = '0;

  logic                     in_ready;
  logic                     out_valid;
  logic [2:0]               mode_code;
  logic                     pump_on;
  logic                     fan_on;
  logic                     heater_on;
  logic                     fault_lamp_on;
  logic                     charge_enable;
  logic [PCT_W-1:0]         torque_limit;
  logic [PCT_W-1:0]         charge_limit;
  logic [1:0]               fault_code;
  result_t                  observed;

  thermal_scoreboard        sb;
  int unsigned              sender_idle_pct = 0;
  int unsigned              stall_pct       = 0;
  // Thresholds last programmed; the random walk aims at them.
  logic signed [TEMP_W-1:0] reg_vals [8];
  int                       walk_temp       = 200;
  logic                     walk_charging   = 1'b0;

  battery_thermal_mode_controller u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .status_fresh     (status_fresh),
    .pack_temperature (pack_temperature),
    .charge_mode      (charge_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mode_code        (mode_code),
    .pump_on          (pump_on),
    .fan_on           (fan_on),
    .heater_on        (heater_on),
    .fault_lamp_on    (fault_lamp_on),
    .charge_enable    (charge_enable),
    .torque_limit     (torque_limit),
    .charge_limit     (charge_limit),
    .fault_code       (fault_code),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Pack the result ports in the field order of result_t.
  assign observed = {mode_code, pump_on, fan_on, heater_on, fault_lamp_on, charge_enable,
                     torque_limit, charge_limit, fault_code};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: stall at random, at the rate the current phase sets.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: sample pre-edge values, so register writes, accepted ticks and
  // results all reach the scoreboard in the order the block sees them.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.log_tick(status_fresh, pack_temperature, charge_mode);
      if (out_valid && out_ready) sb.check_outcome(observed);
    end
  end

  // Present one tick and hold it until the beat is taken. Idle first at random;
  // valid drops only in a step where it is not raised again.
  task automatic send_tick(input logic fresh, input logic signed [TEMP_W-1:0] temp,
                           input logic charging);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid         <= 1'b1;
    status_fresh     <= fresh;
    pack_temperature <= temp;
    charge_mode      <= charging;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every queued outcome has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Pick a threshold set and write all eight registers on back-to-back cycles.
  task automatic program_regs(input cfg_style_t style);
    int                base;
    logic [TEMP_W-1:0] pct_word;
    // Junk in the upper bits of the percent word must be dropped by the block.
    pct_word = 16'($urandom);
    case (style)
      CFG_DEFAULT: begin
        reg_vals[REG_PRECOND_ON]  = 16'sd50;
        reg_vals[REG_PRECOND_OFF] = 16'sd150;
        reg_vals[REG_COOL_ON]     = 16'sd400;
        reg_vals[REG_COOL_OFF]    = 16'sd350;
        reg_vals[REG_DERATE_ON]   = 16'sd500;
        reg_vals[REG_DERATE_OFF]  = 16'sd450;
        reg_vals[REG_SHUTDOWN]    = 16'sd600;
        pct_word[PCT_W-1:0]       = 7'd50;
      end
      CFG_ORDERED: begin
        // Sensible ladder with random spacing, hysteresis bands included.
        base = int'($urandom_range(300)) - 200;
        reg_vals[REG_PRECOND_ON]  = 16'(base);
        reg_vals[REG_PRECOND_OFF] = 16'(base + int'($urandom_range(150)));
        base = int'($urandom_range(150)) + 250;
        reg_vals[REG_COOL_OFF]    = 16'(base);
        base += int'($urandom_range(80));
        reg_vals[REG_COOL_ON]     = 16'(base);
        base += int'($urandom_range(80));
        reg_vals[REG_DERATE_OFF]  = 16'(base);
        base += int'($urandom_range(80));
        reg_vals[REG_DERATE_ON]   = 16'(base);
        base += int'($urandom_range(150));
        reg_vals[REG_SHUTDOWN]    = 16'(base);
      end
      CFG_EXTREME: begin
        for (int k = 0; k < 7; k++) reg_vals[k] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        case ($urandom_range(3))
          0: pct_word[PCT_W-1:0] = 7'd0;
          1: pct_word[PCT_W-1:0] = 7'd100;
          2: pct_word[PCT_W-1:0] = 7'd101;
          default: pct_word[PCT_W-1:0] = 7'd127;
        endcase
      end
      default: begin
        // Thresholds in any order at all; priority alone decides.
        for (int k = 0; k < 7; k++) reg_vals[k] = 16'($urandom);
      end
    endcase
    reg_vals[REG_DERATE_PCT] = pct_word;
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(k);
      cfg_data  <= reg_vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly a random walk of the temperature with an occasional charge toggle,
  // aimed at the thresholds now and then so hysteresis bands get crossed both
  // ways; the rest is stale status, wild jumps and the range ends.
  task automatic send_random_tick();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    if (pick < 65) begin
      walk_temp += int'($urandom_range(60)) - 30;
    end else if (pick < 85) begin
      k         = $urandom_range(6);
      walk_temp = int'(reg_vals[k]) + int'($urandom_range(6)) - 3;
    end else if (pick < 95) begin
      walk_temp = int'($signed(16'($urandom)));
    end else begin
      walk_temp = $urandom_range(1) ? 32767 : -32768;
    end
    if (walk_temp > 32767) walk_temp = 32767;
    if (walk_temp < -32768) walk_temp = -32768;
    if ($urandom_range(99) < 10) walk_charging = ~walk_charging;
    send_tick($urandom_range(99) >= 8, 16'(walk_temp), walk_charging);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset thresholds, no idling.
    send_tick(1'b0, 16'sh7FFF, 1'b1);   // stale status at the hottest reading
    send_tick(1'b0, 16'sh8000, 1'b0);   // stale status at the coldest reading
    send_tick(1'b1, 16'sd200, 1'b0);    // normal while driving: no charge enable
    send_tick(1'b1, 16'sd200, 1'b1);    // normal while charging: charge enable
    send_tick(1'b1, 16'sd50, 1'b1);     // heating starts right at its threshold
    send_tick(1'b1, 16'sd149, 1'b1);    // heating held inside its band
    send_tick(1'b1, 16'sd150, 1'b1);    // heating released at the off point
    send_tick(1'b1, 16'sd100, 1'b1);    // inside the band but not latched
    send_tick(1'b1, 16'sh8000, 1'b1);   // coldest reading while charging
    send_tick(1'b0, 16'sd0, 1'b1);      // stale status clears the heating latch
    send_tick(1'b1, 16'sd100, 1'b1);
    send_tick(1'b1, -16'sd40, 1'b0);    // cold pack while driving: no heating
    send_tick(1'b1, 16'sd400, 1'b0);    // cooling starts
    send_tick(1'b1, 16'sd350, 1'b0);    // cooling held at its off point
    send_tick(1'b1, 16'sd349, 1'b0);    // cooling released
    send_tick(1'b1, 16'sd399, 1'b0);    // just short of cooling, not latched
    send_tick(1'b1, 16'sd500, 1'b0);    // derate starts
    send_tick(1'b1, 16'sd450, 1'b0);    // derate held at its off point
    send_tick(1'b1, 16'sd449, 1'b0);    // derate drops into latched cooling
    send_tick(1'b1, 16'sd500, 1'b1);    // derate while charging
    send_tick(1'b0, 16'sd500, 1'b1);    // stale status clears the cooling latch
    send_tick(1'b1, 16'sd380, 1'b0);
    send_tick(1'b1, 16'sd600, 1'b1);    // shutdown at its threshold
    send_tick(1'b1, 16'sh7FFF, 1'b0);   // hottest reading
    send_tick(1'b1, 16'sd599, 1'b0);    // back out of shutdown into derate
    wait_drained();

    // Random phases: rotate threshold styles and handshake patterns.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 50; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 50; end
        default: begin sender_idle_pct = 21; stall_pct = 21; end
      endcase
      program_regs(phase == 0 ? CFG_DEFAULT : cfg_style_t'(1 + (phase - 1) % 3));
      walk_temp = int'(reg_vals[REG_COOL_OFF]);
      for (int unsigned i = 0; i < TICKS_PER_PHASE; i++) begin
        // Halfway through, hold the sender until the block has emptied.
        if (i == TICKS_PER_PHASE / 2) wait_drained();
        send_random_tick();
      end
      wait_drained();
    end

    // Allow a stray late beat to show up before the verdict.
    repeat (4) @(posedge clk);
    $display("tb: %0d results checked over %0d threshold settings, %0d mismatches",
             sb.checked, PHASES + 1, sb.mismatches);
    $display("tb: modes normal %0d precond %0d cooling %0d derate %0d shutdown %0d timeout %0d",
             sb.mode_count[MODE_NORMAL], sb.mode_count[MODE_PRECOND],
             sb.mode_count[MODE_COOLING], sb.mode_count[MODE_DERATE],
             sb.mode_count[MODE_SHUTDOWN], sb.mode_count[MODE_TIMEOUT]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
